>>> sv/bbl_pkg.sv
// Shared types, constants and the reciprocal table of the 3x3 box blur.
`timescale 1ns / 1ps
package bbl_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int HEIGHT_LIMIT  = 4096;
  localparam int CFG_W_BITS    = 11;
  localparam int CFG_H_BITS    = 13;
  localparam int CFG_BITS      = 13;
  localparam int ROW_BITS      = 14;
  localparam int PIX_BITS      = 8;
  localparam int RGB_BITS      = 24;
  localparam int SUM_BITS      = 12;
  localparam int NUM_BITS      = 13;
  localparam int CNT_BITS      = 4;
  localparam int RECIP_BITS    = 20;
  localparam int RECIP_SHIFT   = 20;
  localparam int NUM_LANES     = 3;
  localparam int WIN_SIZE      = 9;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef struct packed {
    logic                sum_en;
    logic                mul_en;
    logic [8:0]          mask;
    logic [CNT_BITS-1:0] count;
  } lane_ctl_t;

  // ceil(2^20 / (2*count)); exact for every numerator up to 2*9*255+9.
  function automatic logic [RECIP_BITS-1:0] recip(input logic [CNT_BITS-1:0] cnt);
    logic [RECIP_BITS-1:0] r;
    case (cnt)
      4'd2:    r = 20'd262144;
      4'd3:    r = 20'd174763;
      4'd4:    r = 20'd131072;
      4'd5:    r = 20'd104858;
      4'd6:    r = 20'd87382;
      4'd7:    r = 20'd74899;
      4'd8:    r = 20'd65536;
      4'd9:    r = 20'd58255;
      default: r = 20'd524288;
    endcase
    return r;
  endfunction

endpackage

>>> sv/bbl_ram.sv
// Simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module bbl_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/bbl_lane.sv
// One color channel lane: masked 3x3 sum, then rounded division by the count.
`timescale 1ns / 1ps
module bbl_lane (
  input  logic                         clk_i,
  input  bbl_pkg::lane_ctl_t           ctl_i,
  input  logic [bbl_pkg::PIX_BITS-1:0] pix_i [9],
  output logic [bbl_pkg::PIX_BITS-1:0] mean_o
);
  import bbl_pkg::*;

  logic [SUM_BITS-1:0]               sum_d, sum_q;
  logic [CNT_BITS-1:0]               cnt_q;
  logic [NUM_BITS-1:0]               num;
  logic [NUM_BITS+RECIP_BITS-1:0]    prod_q;

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < WIN_SIZE; i++) begin
      if (ctl_i.mask[i]) begin
        sum_d = sum_d + SUM_BITS'(pix_i[i]);
      end
    end
  end

  // Half-up rounding: (2*sum + count) / (2*count).
  assign num = {sum_q, 1'b0} + NUM_BITS'(cnt_q);

  always_ff @(posedge clk_i) begin
    if (ctl_i.sum_en) begin
      sum_q <= sum_d;
      cnt_q <= ctl_i.count;
    end
    if (ctl_i.mul_en) begin
      prod_q <= (NUM_BITS+RECIP_BITS)'(num) * (NUM_BITS+RECIP_BITS)'(recip(cnt_q));
    end
  end

  assign mean_o = prod_q[RECIP_SHIFT +: PIX_BITS];

endmodule

>>> sv/box_blur_3x3_edge_clipped_unit.sv
// 3x3 edge-clipped box blur over an RGB raster stream.
//
// Input beats on s_axis carry one pixel (tuser = 0) or a flush tick
// (tuser = 1). Output beats on m_axis carry the blurred pixel one row and
// one pixel behind the input; tlast marks the last pixel of the frame.
// After the last input pixel, width+1 flush beats drain the bottom row
// (the first gives nothing for a one-row frame). Flush beats before the
// frame's last pixel are dropped.
// Each beat passes through line store read, window shift and lane sums,
// reciprocal multiply and output load, in that order. The line store read
// port and the lane multiply are used once per beat, and a new beat is
// taken only after the previous one has finished.
// A finished pixel sits in the output register; the next beat is taken
// while it waits, and processing stalls only at the output load step when
// the register is still full.
// Reset clears the counters, the window and the output valid flag and loads
// width 640 and height 480. A write on the config port starts a new frame;
// the line stores need no clearing.
`timescale 1ns / 1ps
module box_blur_3x3_edge_clipped_unit #(
  parameter int MAX_WIDTH = bbl_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [bbl_pkg::CFG_BITS-1:0] cfg_wdata_i,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [23:0]                  s_axis_tdata_i,  // red_in, green_in, blue_in
  input  logic                         s_axis_tuser_i,  // op
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [23:0]                  m_axis_tdata_o,  // red_out, green_out, blue_out
  output logic                         m_axis_tlast_o   // frame_end
);
  import bbl_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SUM  = 4'b0010,
    S_MUL  = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [CFG_W_BITS-1:0] cfg_w_q;
  logic [CFG_H_BITS-1:0] cfg_h_q;
  logic [XW:0]           w_eff;
  logic [CFG_H_BITS-1:0] h_eff;
  logic [CFG_BITS-1:0]   w_ext;

  logic [XW-1:0]         in_col_q, x_eff;
  logic [ROW_BITS-1:0]   in_row_q;
  logic [XW-1:0]         out_col_q;
  logic [ROW_BITS-1:0]   out_row_q;
  logic [RGB_BITS-1:0]   win_q [WIN_SIZE];
  logic [RGB_BITS-1:0]   win_sh [WIN_SIZE];
  logic [RGB_BITS-1:0]   win_use [WIN_SIZE];

  logic                  flush_q;
  logic [RGB_BITS-1:0]   pix_q;
  logic                  emit_q, last_q;
  logic [RGB_BITS-1:0]   top_rd, mid_rd;

  logic                  accept, drop, flush_eff;
  logic                  emit, last, col_end, out_col_end;
  logic                  cs2, row_top_ok, row_bot_ok, left_ok, right_ok;
  logic [8:0]            mask;
  lane_ctl_t             ctl;
  logic [PIX_BITS-1:0]   lane_pix [NUM_LANES][WIN_SIZE];
  logic [PIX_BITS-1:0]   lane_mean [NUM_LANES];
  logic                  out_load;
  logic                  m_valid_q;

  // Effective frame size after clamping.
  assign w_ext = CFG_BITS'(cfg_w_q);
  always_comb begin
    if (w_ext == '0) begin
      w_eff = (XW+1)'(1);
    end else if (w_ext > CFG_BITS'(MAX_WIDTH)) begin
      w_eff = (XW+1)'(MAX_WIDTH);
    end else begin
      w_eff = w_ext[XW:0];
    end
    if (cfg_h_q == '0) begin
      h_eff = CFG_H_BITS'(1);
    end else if (cfg_h_q > CFG_H_BITS'(HEIGHT_LIMIT)) begin
      h_eff = CFG_H_BITS'(HEIGHT_LIMIT);
    end else begin
      h_eff = cfg_h_q;
    end
  end

  assign x_eff = ({1'b0, in_col_q} >= w_eff) ? '0 : in_col_q;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept    = s_axis_tvalid_i && s_axis_tready_o;
  assign flush_eff = (s_axis_tuser_i == OP_FLUSH) || (in_row_q >= ROW_BITS'(h_eff));
  // A flush tick inside the frame is dropped: the FSM stays idle and the counters hold.
  assign drop      = (s_axis_tuser_i == OP_FLUSH) && (in_row_q < ROW_BITS'(h_eff));

  bbl_ram #(.WIDTH(RGB_BITS), .DEPTH(MAX_WIDTH)) u_upper (
    .clk_i   (clk_i),
    .we_i    (state_q == S_SUM),
    .waddr_i (in_col_q),
    .wdata_i (mid_rd),
    .re_i    (accept),
    .raddr_i (x_eff),
    .rdata_o (top_rd)
  );

  bbl_ram #(.WIDTH(RGB_BITS), .DEPTH(MAX_WIDTH)) u_middle (
    .clk_i   (clk_i),
    .we_i    (state_q == S_SUM),
    .waddr_i (in_col_q),
    .wdata_i (pix_q),
    .re_i    (accept),
    .raddr_i (x_eff),
    .rdata_o (mid_rd)
  );

  // Window shift and the clipping mask, both evaluated in S_SUM.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_sh[k*3]   = win_q[k*3+1];
      win_sh[k*3+1] = win_q[k*3+2];
    end
    win_sh[2] = top_rd;
    win_sh[5] = mid_rd;
    win_sh[8] = pix_q;
  end

  // At the start of a row the window shifts after summing, so the centre
  // sits in the right column of the old window.
  assign cs2 = (in_col_q == '0);
  always_comb begin
    for (int i = 0; i < WIN_SIZE; i++) begin
      win_use[i] = cs2 ? win_q[i] : win_sh[i];
    end
  end

  assign emit        = (in_row_q >= ROW_BITS'(1)) && (!cs2 || in_row_q >= ROW_BITS'(2));
  assign col_end     = ({1'b0, in_col_q} + (XW+1)'(1)) >= w_eff;
  assign out_col_end = ({1'b0, out_col_q} + (XW+1)'(1)) >= w_eff;
  assign row_top_ok  = (out_row_q != '0);
  assign row_bot_ok  = (out_row_q + ROW_BITS'(1)) < ROW_BITS'(h_eff);
  assign left_ok     = (out_col_q != '0);
  assign right_ok    = !out_col_end;
  assign last        = !row_bot_ok && out_col_end;

  always_comb begin
    logic [2:0] col_m;
    logic [2:0] row_m;
    col_m = cs2 ? {1'b1, left_ok, 1'b0} : {right_ok, 1'b1, left_ok};
    row_m = {row_bot_ok, 1'b1, row_top_ok};
    for (int r = 0; r < 3; r++) begin
      for (int s = 0; s < 3; s++) begin
        mask[r*3+s] = emit && row_m[r] && col_m[s];
      end
    end
  end

  assign ctl.sum_en = (state_q == S_SUM);
  assign ctl.mul_en = (state_q == S_MUL);
  assign ctl.mask   = mask;
  assign ctl.count  = CNT_BITS'($countones(mask));

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      for (int i = 0; i < WIN_SIZE; i++) begin
        lane_pix[l][i] = win_use[i][RGB_BITS-PIX_BITS*(l+1) +: PIX_BITS];
      end
    end
  end

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    bbl_lane u_lane (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .pix_i  (lane_pix[l]),
      .mean_o (lane_mean[l])
    );
  end

  assign out_load = (state_q == S_OUT) && emit_q && (!m_valid_q || m_axis_tready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (accept && !drop) state_d = S_SUM;
      S_SUM:   state_d = S_MUL;
      S_MUL:   state_d = S_OUT;
      S_OUT:   if (!emit_q || out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Internally red sits in the top byte of a pixel word.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      flush_q <= flush_eff;
      pix_q   <= flush_eff ? '0 :
                 {s_axis_tdata_i[7:0], s_axis_tdata_i[15:8], s_axis_tdata_i[23:16]};
    end
    if (state_q == S_SUM) begin
      emit_q <= emit;
      last_q <= last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cfg_w_q   <= CFG_W_BITS'(640);
      cfg_h_q   <= CFG_H_BITS'(480);
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      m_valid_q <= 1'b0;
      for (int i = 0; i < WIN_SIZE; i++) win_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_WIDTH) begin
          cfg_w_q <= cfg_wdata_i[CFG_W_BITS-1:0];
        end else begin
          cfg_h_q <= cfg_wdata_i[CFG_H_BITS-1:0];
        end
        in_col_q  <= '0;
        in_row_q  <= '0;
        out_col_q <= '0;
        out_row_q <= '0;
        for (int i = 0; i < WIN_SIZE; i++) win_q[i] <= '0;
      end else if (state_q == S_SUM) begin
        if (emit && last) begin
          in_col_q  <= '0;
          in_row_q  <= '0;
          out_col_q <= '0;
          out_row_q <= '0;
          for (int i = 0; i < WIN_SIZE; i++) win_q[i] <= '0;
        end else begin
          for (int i = 0; i < WIN_SIZE; i++) win_q[i] <= win_sh[i];
          if (col_end) begin
            in_col_q <= '0;
            in_row_q <= in_row_q + ROW_BITS'(1);
          end else begin
            in_col_q <= in_col_q + XW'(1);
          end
          if (emit) begin
            if (out_col_end) begin
              out_col_q <= '0;
              out_row_q <= out_row_q + ROW_BITS'(1);
            end else begin
              out_col_q <= out_col_q + XW'(1);
            end
          end
        end
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_axis_tdata_o <= {lane_mean[2], lane_mean[1], lane_mean[0]};
      m_axis_tlast_o <= last_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;

  // The output register is never overwritten while it still holds a beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!m_valid_q || m_axis_tready_i))
    else $error("output register overwritten");

  // Every emitted result has a neighbour count of at least 1 and at most 9.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SUM && emit) |-> (ctl.count != '0 && ctl.count <= CNT_BITS'(WIN_SIZE)))
    else $error("neighbor count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_row_q < ROW_BITS'(h_eff))
    else $error("output row beyond frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, in_col_q} < w_eff) && ({1'b0, out_col_q} < w_eff))
    else $error("column counter beyond frame width");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SUM && flush_q) |-> (pix_q == '0))
    else $error("flush tick carries pixel data");

endmodule
